@@ hdl/smm_pkg.sv @@
// Package for the second-moment matrix block: payload structs, control struct
// and fixed widths. Used by every module in hdl/; depends on nothing.
package smm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 48;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = 3;
    localparam int COLS_W   = 4;
    localparam int COUNT_W  = 16;
    // Every cell keeps one sum slot per column offset.
    localparam int SLOTS    = 8;
    // Quotient bits that the divider resolves; a mean never needs more.
    localparam int QUO_W    = 31;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_set;
    } smm_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic                      last;
        logic                      empty_set;
        logic                      row_overflow;
    } smm_out_t;

    typedef struct packed {
        logic                       load;
        logic [IDX_W-1:0]           pos;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       pass_load;
        logic                       mac_en;
        logic [IDX_W-1:0]           step;
        logic [COLS_W-1:0]          cols;
        logic                       clear;
        logic [IDX_W-1:0]           rd_ofs;
    } smm_ctl_t;

endpackage

@@ hdl/smm_cell.sv @@
// One column cell: buffers its row element, passes row elements down the chain
// and accumulates its row of the upper-triangle sums. Depends on smm_pkg.
module smm_cell
    import smm_pkg::*;
#(
    parameter int COL = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  smm_ctl_t                   ctl,
    input  logic signed [SAMPLE_W-1:0] pass_in,
    output logic signed [SAMPLE_W-1:0] pass_out,
    output logic signed [SUM_W-1:0]    rd_sum
);

    logic signed [SAMPLE_W-1:0] buf_reg, buf_next;
    logic signed [SAMPLE_W-1:0] pass_reg, pass_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       en_reg;
    logic [IDX_W-1:0]           slot_reg;
    logic signed [SUM_W-1:0]    sums_reg [SLOTS];
    logic                       wr;
    logic                       in_range;

    assign wr       = ctl.load && (ctl.pos == IDX_W'(COL));
    assign in_range = ({1'b0, ctl.step} + COLS_W'(COL)) < ctl.cols;

    always_comb
    begin
        buf_next = buf_reg;
        if (ctl.clear)
        begin
            buf_next = '0;
        end
        else if (wr)
        begin
            buf_next = ctl.sample;
        end
    end

    // After loading, pass_reg holds the element COL+step of the row.
    always_comb
    begin
        pass_next = pass_reg;
        if (ctl.pass_load)
        begin
            pass_next = wr ? ctl.sample : buf_reg;
        end
        else if (ctl.mac_en)
        begin
            pass_next = pass_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            pass_reg <= '0;
            en_reg   <= 1'b0;
            slot_reg <= '0;
            for (int k = 0; k < SLOTS; k++)
            begin
                sums_reg[k] <= '0;
            end
        end
        else
        begin
            buf_reg  <= buf_next;
            pass_reg <= pass_next;
            en_reg   <= ctl.mac_en && in_range;
            slot_reg <= ctl.step;
            if (ctl.clear)
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    sums_reg[k] <= '0;
                end
            end
            else if (en_reg)
            begin
                sums_reg[slot_reg] <= sums_reg[slot_reg] + SUM_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mac_en)
        begin
            prod_reg <= buf_reg * pass_reg;
        end
    end

    assign pass_out = pass_reg;
    assign rd_sum   = sums_reg[ctl.rd_ofs];

endmodule

@@ hdl/smm_div.sv @@
// Sequential signed divider, one quotient bit per cycle, truncating toward
// zero. Divides a 48-bit sum by the 16-bit row count. Depends on smm_pkg.
module smm_div
    import smm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0]        divisor,
    output logic                      done,
    output logic signed [VALUE_W-1:0] quotient
);

    logic                 run_reg;
    logic                 done_reg;
    logic [4:0]           cnt_reg;
    logic                 neg_reg;
    logic [COUNT_W:0]     rem_reg;
    logic [QUO_W-1:0]     q_reg;
    logic [COUNT_W-1:0]   d_reg;
    logic [SUM_W-1:0]     mag;
    logic [COUNT_W+1:0]   trial;
    logic                 fits;

    assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
    assign trial = {rem_reg, q_reg[QUO_W-1]};
    assign fits  = trial >= {2'b00, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The high bits of the magnitude are always below the divisor, so they
    // seed the remainder directly.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            rem_reg <= mag[SUM_W-1:QUO_W];
            q_reg   <= mag[QUO_W-1:0];
            d_reg   <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? (COUNT_W+1)'(trial - {2'b00, d_reg})
                            : trial[COUNT_W:0];
            q_reg   <= {q_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -VALUE_W'({1'b0, q_reg}) : VALUE_W'({1'b0, q_reg});

endmodule

@@ hdl/second_moment_matrix.sv @@
// Top level of the second-moment matrix block: control, cell chain, divider.
// Depends on smm_pkg, smm_cell and smm_div.
//
// A sample that neither completes a row nor ends a set leaves busy low. A
// sample that completes a row below the row limit keeps busy high through
// S_MAC and S_DRAIN while the products are stepped through the cell chain,
// one column offset per cycle. On the last sample of a set each of the
// columns*columns entries loads the bit-serial divider and waits for its
// quotient (none when no row was received); S_CLEAR then clears the sums.
// Results come out one per strobe and cannot be held off by the receiver.
module second_moment_matrix
    import smm_pkg::*;
#(
    parameter int MAX_COLUMNS = 8,
    parameter int MAX_ROWS    = 65535
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  smm_in_t           item,
    output logic              busy,
    output smm_out_t          result,
    output logic              result_valid,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [COLS_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAC    = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_ESTART = 3'd3;
    localparam logic [2:0] S_EWAIT  = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [COLS_W-1:0]   columns_reg;
    logic [COLS_W-1:0]   eff_cols;
    logic [COLS_W-1:0]   cols_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                ovf_reg;
    logic                final_reg;
    logic [IDX_W-1:0]    step_reg;
    logic [IDX_W-1:0]    ei_reg, ej_reg;
    logic                accept;
    logic                row_done;
    logic                row_full;
    logic                advance;
    logic                is_last;
    logic [IDX_W-1:0]    lo_idx, hi_idx;
    smm_ctl_t            ctl;
    logic signed [SAMPLE_W-1:0] pass [MAX_COLUMNS+1];
    logic signed [SUM_W-1:0]    cell_sum [MAX_COLUMNS];
    logic signed [SUM_W-1:0]    sel_sum;
    logic                div_start;
    logic                div_done;
    logic signed [VALUE_W-1:0] div_q;
    smm_out_t            result_reg;
    logic                strobe_reg;

    assign accept    = start && !busy;
    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        eff_cols = columns_reg;
        if (columns_reg == '0)
        begin
            eff_cols = COLS_W'(1);
        end
        else if (columns_reg > COLS_W'(MAX_COLUMNS))
        begin
            eff_cols = COLS_W'(MAX_COLUMNS);
        end
    end

    assign row_done = {1'b0, pos_reg} >= (eff_cols - COLS_W'(1));
    assign row_full = count_reg >= COUNT_W'(MAX_ROWS);
    assign is_last  = ({1'b0, ei_reg} == cols_reg - COLS_W'(1))
                   && ({1'b0, ej_reg} == cols_reg - COLS_W'(1));
    assign lo_idx   = (ei_reg < ej_reg) ? ei_reg : ej_reg;
    assign hi_idx   = (ei_reg < ej_reg) ? ej_reg : ei_reg;

    always_comb
    begin
        ctl.load      = accept;
        ctl.pos       = pos_reg;
        ctl.sample    = item.sample;
        ctl.pass_load = accept && row_done && !row_full;
        ctl.mac_en    = state_reg == S_MAC;
        ctl.step      = step_reg;
        ctl.cols      = cols_reg;
        ctl.clear     = state_reg == S_CLEAR;
        ctl.rd_ofs    = hi_idx - lo_idx;
    end

    assign pass[MAX_COLUMNS] = '0;

    for (genvar g = 0; g < MAX_COLUMNS; g++)
    begin : g_cell
        smm_cell #(
            .COL (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .pass_in  (pass[g+1]),
            .pass_out (pass[g]),
            .rd_sum   (cell_sum[g])
        );
    end

    always_comb
    begin
        sel_sum = '0;
        for (int k = 0; k < MAX_COLUMNS; k++)
        begin
            if (lo_idx == IDX_W'(k))
            begin
                sel_sum = cell_sum[k];
            end
        end
    end

    assign div_start = (state_reg == S_ESTART) && (count_reg != '0);

    smm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sel_sum),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign advance = ((state_reg == S_ESTART) && (count_reg == '0))
                  || ((state_reg == S_EWAIT) && div_done);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (row_done && !row_full)
                    begin
                        state_next = S_MAC;
                    end
                    else if (item.last_of_set)
                    begin
                        state_next = S_ESTART;
                    end
                end
            end
            S_MAC:
            begin
                if ({1'b0, step_reg} == cols_reg - COLS_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = final_reg ? S_ESTART : S_IDLE;
            end
            S_ESTART:
            begin
                if (count_reg == '0)
                begin
                    state_next = is_last ? S_CLEAR : S_ESTART;
                end
                else
                begin
                    state_next = S_EWAIT;
                end
            end
            S_EWAIT:
            begin
                if (div_done)
                begin
                    state_next = is_last ? S_CLEAR : S_ESTART;
                end
            end
            S_CLEAR:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            columns_reg <= COLS_W'(8);
            cols_reg    <= COLS_W'(1);
            pos_reg     <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            final_reg   <= 1'b0;
            step_reg    <= '0;
            ei_reg      <= '0;
            ej_reg      <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= advance;
            if (cfg_valid && cfg_ready)
            begin
                columns_reg <= cfg_data;
            end
            if (accept)
            begin
                cols_reg  <= eff_cols;
                final_reg <= item.last_of_set;
                step_reg  <= '0;
                ei_reg    <= '0;
                ej_reg    <= '0;
                if (row_done)
                begin
                    pos_reg <= '0;
                    if (row_full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                end
                else
                begin
                    pos_reg <= pos_reg + IDX_W'(1);
                end
            end
            if (state_reg == S_MAC)
            begin
                step_reg <= step_reg + IDX_W'(1);
            end
            if (advance)
            begin
                if ({1'b0, ej_reg} == cols_reg - COLS_W'(1))
                begin
                    ej_reg <= '0;
                    ei_reg <= ei_reg + IDX_W'(1);
                end
                else
                begin
                    ej_reg <= ej_reg + IDX_W'(1);
                end
            end
            if (state_reg == S_CLEAR)
            begin
                pos_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.value        <= (count_reg == '0) ? '0 : div_q;
            result_reg.row_index    <= ei_reg;
            result_reg.col_index    <= ej_reg;
            result_reg.last         <= is_last;
            result_reg.empty_set    <= count_reg == '0;
            result_reg.row_overflow <= ovf_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = strobe_reg;

`ifndef SYNTH
    // The final entry of a matrix is always followed by the clearing cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> (state_reg == S_CLEAR))
        else $error("last entry not followed by clear");

    // A transfer of an input item never coincides with a result strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !result_valid)
        else $error("result strobe while idle");

    // The row count never passes its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_ROWS))
        else $error("row count beyond limit");
`endif

endmodule

@@ sim/tb_second_moment_matrix.sv @@
`timescale 1ns / 100ps
// Testbench for second_moment_matrix: random and directed data sets, checked
// entry by entry against a built-in predictor. Depends on smm_pkg and the RTL.
module tb_second_moment_matrix;
    import smm_pkg::*;

    localparam int ROW_LIMIT   = 65535;
    localparam int CYCLE_LIMIT = 3000000;

    // Predicts the emitted matrix from the accepted samples and checks it.
    class moment_board;
        logic [COLS_W-1:0] columns;
        int                row_buf[8];
        longint            pair_sum[8][8];
        int                col_pos;
        int                row_count;
        bit                dropped_rows;
        smm_out_t          pending_entries[$];
        int                errors;

        function new();
            columns = 4'd8;
            errors  = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            foreach (row_buf[i]) row_buf[i] = 0;
            foreach (pair_sum[i, j]) pair_sum[i][j] = 0;
            col_pos      = 0;
            row_count    = 0;
            dropped_rows = 0;
        endfunction

        function int used_columns();
            if (columns == 0) return 1;
            if (columns > 8) return 8;
            return int'(columns);
        endfunction

        function void take_sample(smm_in_t smp);
            int       cols;
            longint   mean;
            smm_out_t ent;
            cols = used_columns();
            row_buf[col_pos] = int'(smp.sample);
            // A row completes once the position reaches the last column,
            // even when the count shrank while the row was being filled.
            if (col_pos >= cols - 1) begin
                if (row_count >= ROW_LIMIT) begin
                    dropped_rows = 1;
                end
                else begin
                    for (int i = 0; i < cols; i++)
                        for (int j = i; j < cols; j++)
                            pair_sum[i][j] += longint'(row_buf[i] * row_buf[j]);
                    row_count++;
                end
                col_pos = 0;
            end
            else begin
                col_pos++;
            end
            if (!smp.last_of_set) return;
            for (int i = 0; i < cols; i++) begin
                for (int j = 0; j < cols; j++) begin
                    mean = 0;
                    if (row_count != 0)
                        mean = (i <= j ? pair_sum[i][j] : pair_sum[j][i]) / row_count;
                    ent.value        = mean[31:0];
                    ent.row_index    = IDX_W'(i);
                    ent.col_index    = IDX_W'(j);
                    ent.last         = (i == cols - 1) && (j == cols - 1);
                    ent.empty_set    = (row_count == 0);
                    ent.row_overflow = dropped_rows;
                    pending_entries.push_back(ent);
                end
            end
            clear_sums();
        endfunction

        function void check_entry(smm_out_t got);
            smm_out_t exp_ent;
            if (pending_entries.size() == 0) begin
                $display("%0t: unexpected entry, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            exp_ent = pending_entries.pop_front();
            if (got.value !== exp_ent.value)
                report("value", exp_ent.value, got.value);
            if (got.row_index !== exp_ent.row_index)
                report("row_index", exp_ent.row_index, got.row_index);
            if (got.col_index !== exp_ent.col_index)
                report("col_index", exp_ent.col_index, got.col_index);
            if (got.last !== exp_ent.last)
                report("last", exp_ent.last, got.last);
            if (got.empty_set !== exp_ent.empty_set)
                report("empty_set", exp_ent.empty_set, got.empty_set);
            if (got.row_overflow !== exp_ent.row_overflow)
                report("row_overflow", exp_ent.row_overflow, got.row_overflow);
        endfunction

        function void report(string field, longint exp_v, longint act_v);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
                     exp_v, act_v);
            errors++;
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    smm_in_t           item;
    logic              busy;
    smm_out_t          result;
    logic              result_valid;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [COLS_W-1:0] cfg_data;

    moment_board board;
    int          cycles;
    bit          steady;

    second_moment_matrix u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_entry(result);
    end

    // Holds start high until the transfer happens, then idles a random gap unless steady is set.
    task automatic send_sample(logic signed [15:0] s, bit fin);
        int gap;
        smm_in_t smp;
        smp.sample      = s;
        smp.last_of_set = fin;
        start <= 1'b1;
        item  <= smp;
        do @(posedge clk); while (busy);
        board.take_sample(smp);
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending_entries.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_columns(logic [COLS_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        board.columns = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    // Full rows with random content, an optional partial row, then the last flag.
    task automatic send_set(int rows, int extra);
        int total;
        total = rows * board.used_columns() + extra;
        if (total == 0) total = 1;
        for (int k = 0; k < total; k++)
            send_sample(pick_sample(), k == total - 1);
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        cycles    = 0;
        steady    = 0;
        board     = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes at the reset width, then a partial trailing row.
        for (int k = 0; k < 8; k++) send_sample(k[0] ? 16'sh8000 : 16'sh7FFF, 0);
        for (int k = 0; k < 8; k++) send_sample(16'sh8000, 0);
        send_sample(16'sh1234, 1);
        // No complete row at all.
        send_sample(16'sh7FFF, 1);
        // Zero is taken as one column, fifteen as eight.
        write_columns(4'd0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh7FFF, 1);
        write_columns(4'd15);
        send_set(1, 0);
        // Column count shrinks while a row is partly filled.
        write_columns(4'd4);
        send_sample(16'sh0003, 0);
        send_sample(-16'sh0005, 0);
        send_sample(16'sh0007, 0);
        write_columns(4'd2);
        drain();
        send_sample(-16'sh0002, 1);

        // Random phases over column settings, some with no idling at all.
        for (int ph = 0; ph < 12; ph++) begin
            write_columns((ph % 6 == 5) ? COLS_W'($urandom_range(9, 15))
                                        : COLS_W'($urandom_range(0, 8)));
            steady = (ph % 4 == 3);
            for (int st = 0; st < 3; st++)
                send_set($urandom_range(0, 5), $urandom_range(0, 2));
        end
        steady = 0;

        write_columns(4'd8);
        send_set(2, 3);

        drain();
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
